@@ hdl/slcp_pkg.sv @@
// Shared types, constants and character helpers for the serial lock command parser.
package slcp_pkg;

   localparam int LINE_BYTES = 32;
   localparam int LINE_DEPTH = LINE_BYTES - 1;
   localparam int LINE_AW    = $clog2(LINE_DEPTH);
   localparam int LEN_W      = $clog2(LINE_BYTES);
   localparam int TIME_W     = 32;
   localparam int CFG_W      = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int POS_W      = 3;

   localparam logic [15:0] HOLD_RESET = 16'd5000;
   localparam logic [15:0] GAP_RESET  = 16'd500;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   typedef enum logic [1:0] {
      REQ_BYTE     = 2'd0,
      REQ_UART_ERR = 2'd1,
      REQ_TICK     = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      RPL_ACK_UNLOCK = 3'd0,
      RPL_ACK_LOCK   = 3'd1,
      RPL_HOLD       = 3'd2,
      RPL_ACK_PING   = 3'd3,
      RPL_ERR_CMD    = 3'd4,
      RPL_ERR_LEN    = 3'd5,
      RPL_AUTOLOCK   = 3'd6
   } reply_type;

   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_UNLOCK = 2'd1,
      ACT_LOCK   = 2'd2
   } act_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_HOLD_TIME = 1'd0,
      REG_GAP_TIME  = 1'd1
   } csr_reg_type;

   typedef struct packed {
      logic [TIME_W-1:0] op_a;
      logic [TIME_W-1:0] op_b;
      logic [CFG_W-1:0]  limit;
   } alu_req_type;

   typedef struct packed {
      logic gt;
      logic ge;
   } alu_rsp_type;

   localparam logic [47:0] WORD_UNLOCK = {"K", "C", "O", "L", "N", "U"};
   localparam logic [31:0] WORD_LOCK   = {"K", "C", "O", "L"};
   localparam logic [31:0] WORD_PING   = {"G", "N", "I", "P"};

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB);
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h61 && c <= 8'h7A) begin
         r = c - 8'h20;
      end
      return r;
   endfunction

   function automatic logic [7:0] unlock_char(input logic [POS_W-1:0] k);
      logic [7:0] r;
      r = CHAR_NUL;
      if (k < POS_W'(6)) begin
         r = WORD_UNLOCK[k*8 +: 8];
      end
      return r;
   endfunction

   function automatic logic [7:0] lock_char(input logic [POS_W-1:0] k);
      logic [7:0] r;
      r = CHAR_NUL;
      if (k < POS_W'(4)) begin
         r = WORD_LOCK[k[1:0]*8 +: 8];
      end
      return r;
   endfunction

   function automatic logic [7:0] ping_char(input logic [POS_W-1:0] k);
      logic [7:0] r;
      r = CHAR_NUL;
      if (k < POS_W'(4)) begin
         r = WORD_PING[k[1:0]*8 +: 8];
      end
      return r;
   endfunction

endpackage

@@ hdl/slcp_ram.sv @@
// Generic single-port-write, registered-read RAM.
module slcp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 31
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

@@ hdl/slcp_alu.sv @@
// Shared modular time-difference unit compared against a millisecond limit.
module slcp_alu (
   input  slcp_pkg::alu_req_type alu_req,
   output slcp_pkg::alu_rsp_type alu_rsp
);
   import slcp_pkg::*;

   logic [TIME_W-1:0] diff;
   logic [TIME_W-1:0] limit_ext;

   assign diff      = alu_req.op_a - alu_req.op_b;
   assign limit_ext = {{(TIME_W-CFG_W){1'b0}}, alu_req.limit};

   assign alu_rsp.gt = diff > limit_ext;
   assign alu_rsp.ge = diff >= limit_ext;

endmodule

@@ hdl/serial_lock_command_parser_core.sv @@
// Top level of the serial lock command parser: sequencer, line buffer and reply register.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_tvalid/tready    | tdata: rx_byte[7:0]; tuser: req_type[1:0]
//  rsp     | out       | rsp_tvalid/tready    | tdata: reply_code[2:0], actuator_cmd[4:3],
//          |           |                      |        lock_open[5], zero[7:6]
//  csr     | in        | csr_valid/csr_ready  | csr_index[0], csr_wdata[15:0]
//
//  req_tready is low while a plain byte, a UART error or a tick is handled.
//  A line end is processed in the two scans of the line buffer, read one byte per cycle.
//  A reply waits in the output register; the sequencer stalls only if a second reply
//  is ready before the first is taken. Synchronous reset restores the register defaults
//  and clears the time counters, the lock flag and the line length.
module serial_lock_command_parser_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // rx_byte[7:0]
   input  logic [1:0]                     req_tuser,   // req_type[1:0]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,   // reply_code[2:0], actuator_cmd[4:3],
                                                       // lock_open[5], zero[7:6]
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [slcp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [slcp_pkg::CFG_W-1:0]     csr_wdata
);
   import slcp_pkg::*;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_GAP    = 11'b000_0000_0010,
      ST_BYTE   = 11'b000_0000_0100,
      ST_SCAN   = 11'b000_0000_1000,
      ST_LEN    = 11'b000_0001_0000,
      ST_MATCH  = 11'b000_0010_0000,
      ST_DECIDE = 11'b000_0100_0000,
      ST_DONE   = 11'b000_1000_0000,
      ST_TICK   = 11'b001_0000_0000,
      ST_AUTO   = 11'b010_0000_0000,
      ST_EMIT   = 11'b100_0000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [CFG_W-1:0]  hold_ff, hold_in;
   logic [CFG_W-1:0]  gap_ff, gap_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [TIME_W-1:0] lbt_ff, lbt_in;
   logic [TIME_W-1:0] unl_time_ff, unl_time_in;
   logic              unlocked_ff, unlocked_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              from_gap_ff, from_gap_in;
   logic              res_have_ff, res_have_in;
   reply_type         res_code_ff, res_code_in;
   act_type           res_act_ff, res_act_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic [7:0]        char_ff, char_in;
   logic [LEN_W-1:0]  ptr_ff, ptr_in;
   logic [LEN_W-1:0]  dptr_ff, dptr_in;
   logic              vld_ff, vld_in;
   logic              seen_ff, seen_in;
   logic [LEN_W-1:0]  s_ff, s_in;
   logic [LEN_W-1:0]  e_ff, e_in;
   logic [LEN_W-1:0]  tlen_ff, tlen_in;
   logic              mu_ff, mu_in;
   logic              ml_ff, ml_in;
   logic              mp_ff, mp_in;

   logic               wr_en;
   logic [LINE_AW-1:0] wr_addr;
   logic [LINE_AW-1:0] rd_addr;
   logic [7:0]         rd_data;
   alu_req_type        alu_req;
   alu_rsp_type        alu_rsp;

   logic [LEN_W-1:0]  tlen;
   logic [POS_W-1:0]  pos;
   logic [7:0]        up_char;
   logic              load_rsp;

   slcp_ram #(
      .WIDTH (8),
      .DEPTH (LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (char_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   slcp_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign wr_addr = len_ff[LINE_AW-1:0];
   assign rd_addr = ptr_ff[LINE_AW-1:0];
   assign tlen    = e_ff - s_ff;
   assign pos     = POS_W'(dptr_ff - s_ff);
   assign up_char = to_upper(rd_data);

   always_comb begin
      hold_in = hold_ff;
      gap_in  = gap_ff;
      if (csr_valid && csr_ready) begin
         case (csr_reg_type'(csr_index))
            REG_HOLD_TIME: hold_in = csr_wdata;
            REG_GAP_TIME:  gap_in  = csr_wdata;
            default:       hold_in = hold_ff;
         endcase
      end
   end

   always_comb begin
      state_in    = state_ff;
      time_in     = time_ff;
      lbt_in      = lbt_ff;
      unl_time_in = unl_time_ff;
      unlocked_in = unlocked_ff;
      len_in      = len_ff;
      from_gap_in = from_gap_ff;
      res_have_in = res_have_ff;
      res_code_in = res_code_ff;
      res_act_in  = res_act_ff;
      char_in     = char_ff;
      ptr_in      = ptr_ff;
      dptr_in     = ptr_ff;
      vld_in      = 1'b0;
      seen_in     = seen_ff;
      s_in        = s_ff;
      e_in        = e_ff;
      tlen_in     = tlen_ff;
      mu_in       = mu_ff;
      ml_in       = ml_ff;
      mp_in       = mp_ff;
      wr_en       = 1'b0;
      load_rsp    = 1'b0;
      alu_req.op_a  = time_ff;
      alu_req.op_b  = unl_time_ff;
      alu_req.limit = hold_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               char_in     = req_tdata;
               res_have_in = 1'b0;
               from_gap_in = 1'b0;
               case (req_kind_type'(req_tuser))
                  REQ_BYTE:     state_in = ST_GAP;
                  REQ_UART_ERR: begin
                     len_in   = '0;
                     state_in = ST_EMIT;
                  end
                  REQ_TICK:     state_in = ST_TICK;
                  default:      state_in = ST_EMIT;
               endcase
            end
         end
         ST_GAP: begin
            alu_req.op_b  = lbt_ff;
            alu_req.limit = gap_ff;
            if (len_ff != '0 && alu_rsp.gt) begin
               from_gap_in = 1'b1;
               ptr_in      = '0;
               seen_in     = 1'b0;
               state_in    = ST_SCAN;
            end else begin
               state_in = ST_BYTE;
            end
         end
         ST_BYTE: begin
            lbt_in      = time_ff;
            from_gap_in = 1'b0;
            if (char_ff == CHAR_CR || char_ff == CHAR_LF) begin
               if (len_ff != '0) begin
                  ptr_in   = '0;
                  seen_in  = 1'b0;
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_EMIT;
               end
            end else if (len_ff < LEN_W'(LINE_DEPTH)) begin
               wr_en    = 1'b1;
               len_in   = len_ff + 1'b1;
               state_in = ST_EMIT;
            end else begin
               len_in      = '0;
               res_have_in = 1'b1;
               res_code_in = RPL_ERR_LEN;
               res_act_in  = ACT_NONE;
               state_in    = ST_EMIT;
            end
         end
         ST_SCAN: begin
            if (ptr_ff < len_ff) begin
               ptr_in = ptr_ff + 1'b1;
               vld_in = 1'b1;
            end
            if (vld_ff) begin
               if (rd_data == CHAR_NUL) begin
                  vld_in   = 1'b0;
                  state_in = ST_LEN;
               end else begin
                  if (!is_blank(rd_data)) begin
                     if (!seen_ff) begin
                        s_in = dptr_ff;
                     end
                     seen_in = 1'b1;
                     e_in    = dptr_ff + 1'b1;
                  end
                  if (dptr_ff == len_ff - 1'b1) begin
                     vld_in   = 1'b0;
                     state_in = ST_LEN;
                  end
               end
            end
         end
         ST_LEN: begin
            tlen_in = tlen;
            if (!seen_ff) begin
               state_in = ST_DONE;
            end else if (tlen == LEN_W'(1) || tlen == LEN_W'(4) || tlen == LEN_W'(6)) begin
               ptr_in   = s_ff;
               mu_in    = 1'b1;
               ml_in    = 1'b1;
               mp_in    = 1'b1;
               state_in = ST_MATCH;
            end else begin
               res_have_in = 1'b1;
               res_code_in = RPL_ERR_CMD;
               res_act_in  = ACT_NONE;
               state_in    = ST_DONE;
            end
         end
         ST_MATCH: begin
            if (ptr_ff < e_ff) begin
               ptr_in = ptr_ff + 1'b1;
               vld_in = 1'b1;
            end
            if (vld_ff) begin
               mu_in = mu_ff && (up_char == unlock_char(pos));
               ml_in = ml_ff && (up_char == lock_char(pos));
               mp_in = mp_ff && (up_char == ping_char(pos));
               if (dptr_ff == e_ff - 1'b1) begin
                  vld_in   = 1'b0;
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            res_have_in = 1'b1;
            res_act_in  = ACT_NONE;
            state_in    = ST_DONE;
            if (mu_ff && (tlen_ff == LEN_W'(1) || tlen_ff == LEN_W'(6))) begin
               unl_time_in = time_ff;
               unlocked_in = 1'b1;
               res_code_in = RPL_ACK_UNLOCK;
               res_act_in  = ACT_UNLOCK;
            end else if (ml_ff && (tlen_ff == LEN_W'(1) || tlen_ff == LEN_W'(4))) begin
               if (alu_rsp.ge) begin
                  unlocked_in = 1'b0;
                  res_code_in = RPL_ACK_LOCK;
                  res_act_in  = ACT_LOCK;
               end else begin
                  res_code_in = RPL_HOLD;
               end
            end else if (mp_ff && (tlen_ff == LEN_W'(1) || tlen_ff == LEN_W'(4))) begin
               res_code_in = RPL_ACK_PING;
            end else begin
               res_code_in = RPL_ERR_CMD;
            end
         end
         ST_DONE: begin
            len_in   = '0;
            state_in = from_gap_ff ? ST_BYTE : ST_EMIT;
         end
         ST_TICK: begin
            time_in  = time_ff + 1'b1;
            state_in = ST_AUTO;
         end
         ST_AUTO: begin
            if (unlocked_ff && alu_rsp.ge) begin
               unlocked_in = 1'b0;
               res_have_in = 1'b1;
               res_code_in = RPL_AUTOLOCK;
               res_act_in  = ACT_LOCK;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!res_have_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               load_rsp    = 1'b1;
               res_have_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load_rsp | (rsp_valid_ff & ~rsp_tready);
   assign rsp_data_in  = load_rsp ? {2'b00, unlocked_ff, res_act_ff, res_code_ff} : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hold_ff      <= HOLD_RESET;
         gap_ff       <= GAP_RESET;
         time_ff      <= '0;
         lbt_ff       <= '0;
         unl_time_ff  <= '0;
         unlocked_ff  <= 1'b0;
         len_ff       <= '0;
         from_gap_ff  <= 1'b0;
         res_have_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hold_ff      <= hold_in;
         gap_ff       <= gap_in;
         time_ff      <= time_in;
         lbt_ff       <= lbt_in;
         unl_time_ff  <= unl_time_in;
         unlocked_ff  <= unlocked_in;
         len_ff       <= len_in;
         from_gap_ff  <= from_gap_in;
         res_have_ff  <= res_have_in;
         rsp_valid_ff <= rsp_valid_in;
         vld_ff       <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      res_code_ff <= res_code_in;
      res_act_ff  <= res_act_in;
      rsp_data_ff <= rsp_data_in;
      char_ff     <= char_in;
      ptr_ff      <= ptr_in;
      dptr_ff     <= dptr_in;
      seen_ff     <= seen_in;
      s_ff        <= s_in;
      e_ff        <= e_in;
      tlen_ff     <= tlen_in;
      mu_ff       <= mu_in;
      ml_ff       <= ml_in;
      mp_ff       <= mp_in;
   end

endmodule

@@ hdl/slcp_checker.sv @@
// Port-level checks for the serial lock command parser, bound to the top level.
module slcp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);
   import slcp_pkg::*;

   logic [2:0] code;
   logic [1:0] act;
   logic       lock_open;

   assign code      = rsp_tdata[2:0];
   assign act       = rsp_tdata[4:3];
   assign lock_open = rsp_tdata[5];

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("reply valid after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while busy");

   a_act_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((act != ACT_LOCK) || !lock_open) && ((act != ACT_UNLOCK) || lock_open))
      else $error("actuator command disagrees with lock state");

   a_act_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (act != ACT_NONE) |->
         (code == RPL_ACK_UNLOCK) || (code == RPL_ACK_LOCK) || (code == RPL_AUTOLOCK))
      else $error("actuator driven on a non-moving reply");

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled reply changed");

endmodule

bind serial_lock_command_parser_core slcp_checker u_slcp_checker (.*);

@@ tb/serial_lock_command_parser_core_tb.sv @@
// Self-checking testbench for the serial lock command parser core: directed and random traffic.
module serial_lock_command_parser_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import slcp_pkg::*;

   localparam logic [1:0] REQ_UNDEFINED = 2'd3;
   localparam int SETTLE_CYCLES = 60;
   localparam int PRINT_CAP = 40;

   typedef struct packed {
      reply_type code;
      act_type   act;
      logic      open;
   } lock_reply_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [7:0]           req_tdata;   // rx_byte[7:0]
   logic [1:0]           req_tuser;   // req_type[1:0]
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [7:0]           rsp_tdata;   // reply_code[2:0], actuator_cmd[4:3], lock_open[5]
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   serial_lock_command_parser_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   logic [15:0] hold_ms;
   logic [15:0] gap_ms;
   logic [31:0] now_ms;
   logic [31:0] last_byte_ms;
   logic [31:0] unlock_ms;
   logic        lock_is_open;
   logic [7:0]  line_buf [LINE_DEPTH];
   int          line_len;

   lock_reply_type pending_replies [$];
   lock_reply_type want_reply;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          words_sent;
   int          replies_seen;
   int          errors;
   int          reply_hist [7];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("%0t ns: timeout, %0d replies still pending", $time, pending_replies.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic void post_reply(reply_type code, act_type act);
      lock_reply_type r;
      r.code = code;
      r.act  = act;
      r.open = lock_is_open;
      pending_replies.push_back(r);
   endfunction

   function automatic void judge_line();
      int          n;
      int          s;
      int          e;
      int          i;
      int          len;
      logic [47:0] txt;
      logic [7:0]  c;
      logic [31:0] elapsed;
      n = 0;
      while (n < line_len && line_buf[n] != CHAR_NUL) n++;
      s = 0;
      e = n;
      while (s < e && (line_buf[s] == CHAR_SPACE || line_buf[s] == CHAR_TAB)) s++;
      while (e > s && (line_buf[e-1] == CHAR_SPACE || line_buf[e-1] == CHAR_TAB)) e--;
      line_len = 0;
      len = e - s;
      if (len == 0) return;
      txt = '0;
      for (i = s; i < e && i < s + 6; i++) begin
         c = line_buf[i];
         if (c >= "a" && c <= "z") c = c - 8'h20;
         txt = {txt[39:0], c};
      end
      if ((len == 6 && txt == "UNLOCK") || (len == 1 && txt == "U")) begin
         unlock_ms = now_ms;
         lock_is_open = 1'b1;
         post_reply(RPL_ACK_UNLOCK, ACT_UNLOCK);
      end else if ((len == 4 && txt == "LOCK") || (len == 1 && txt == "L")) begin
         elapsed = now_ms - unlock_ms;
         if (elapsed >= {16'd0, hold_ms}) begin
            lock_is_open = 1'b0;
            post_reply(RPL_ACK_LOCK, ACT_LOCK);
         end else begin
            post_reply(RPL_HOLD, ACT_NONE);
         end
      end else if ((len == 4 && txt == "PING") || (len == 1 && txt == "P")) begin
         post_reply(RPL_ACK_PING, ACT_NONE);
      end else begin
         post_reply(RPL_ERR_CMD, ACT_NONE);
      end
   endfunction

   function automatic void advance_lock(logic [1:0] kind, logic [7:0] b);
      logic [31:0] elapsed;
      case (kind)
         REQ_BYTE: begin
            elapsed = now_ms - last_byte_ms;
            if (line_len > 0 && elapsed > {16'd0, gap_ms}) judge_line();
            last_byte_ms = now_ms;
            if (b == CHAR_CR || b == CHAR_LF) begin
               if (line_len > 0) judge_line();
            end else if (line_len < LINE_DEPTH) begin
               line_buf[line_len] = b;
               line_len++;
            end else begin
               line_len = 0;
               post_reply(RPL_ERR_LEN, ACT_NONE);
            end
         end
         REQ_UART_ERR: begin
            line_len = 0;
         end
         REQ_TICK: begin
            now_ms = now_ms + 32'd1;
            elapsed = now_ms - unlock_ms;
            if (lock_is_open && elapsed >= {16'd0, hold_ms}) begin
               lock_is_open = 1'b0;
               post_reply(RPL_AUTOLOCK, ACT_LOCK);
            end
         end
         default: begin
         end
      endcase
   endfunction

   task automatic send_word(input logic [1:0] kind, input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = b;
      do @(posedge clock); while (!req_tready);
      advance_lock(kind, b);
      if (kind != REQ_UNDEFINED) words_sent++;
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_word(REQ_BYTE, s[i]);
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_word(REQ_TICK, 8'($urandom_range(255)));
   endtask

   // drain all replies, then let any reply-less line finish
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_reg_type idx, input logic [15:0] value);
      settle();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_HOLD_TIME) hold_ms = value;
      else gap_ms = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_command();
      logic [7:0] cmd [$];
      string      w;
      int         k;
      logic [7:0] c;
      case ($urandom_range(9))
         0: w = "UNLOCK";
         1: w = "U";
         2: w = "LOCK";
         3: w = "L";
         4: w = "PING";
         5: w = "P";
         6: w = "UNLOC";
         7: w = "PINGS";
         8: w = "LOCKK";
         default: w = "";
      endcase
      for (k = 0; k < w.len(); k++) cmd.push_back(w[k]);
      if (w.len() == 0) begin
         repeat ($urandom_range(1, 5)) cmd.push_back(8'($urandom_range(33, 126)));
      end
      for (k = 0; k < cmd.size(); k++) begin
         if (cmd[k] >= "A" && cmd[k] <= "Z" && $urandom_range(1)) cmd[k] = cmd[k] + 8'h20;
      end
      repeat ($urandom_range(2)) cmd.push_front($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
      repeat ($urandom_range(2)) cmd.push_back($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
      if ($urandom_range(9) == 0) begin
         cmd.push_back(CHAR_NUL);
         c = 8'($urandom_range(255));
         if (c == CHAR_CR || c == CHAR_LF) c = "Z";
         cmd.push_back(c);
      end
      foreach (cmd[i]) begin
         if ($urandom_range(19) == 0) send_ticks(1);
         send_word(REQ_BYTE, cmd[i]);
      end
      if (gap_ms <= 16'd8 && $urandom_range(3) == 0) begin
         // leave the line open; the next byte closes it on the gap
         send_ticks(int'(gap_ms) + 1 + $urandom_range(2));
      end else begin
         send_word(REQ_BYTE, $urandom_range(1) ? CHAR_CR : CHAR_LF);
         send_ticks($urandom_range(3));
      end
   endtask

   task automatic send_long_line();
      logic [7:0] c;
      repeat (LINE_DEPTH) begin
         c = 8'($urandom_range(255));
         if (c == CHAR_CR || c == CHAR_LF) c = "A";
         send_word(REQ_BYTE, c);
      end
      if ($urandom_range(1)) begin
         send_word(REQ_BYTE, CHAR_CR);
      end else begin
         c = 8'($urandom_range(255));
         if (c == CHAR_CR || c == CHAR_LF) c = "B";
         send_word(REQ_BYTE, c);
      end
   endtask

   task automatic run_random_traffic(input int count);
      int stop_at;
      int pick;
      stop_at = words_sent + count;
      while (words_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 68) send_command();
         else if (pick < 80) send_ticks($urandom_range(1, 12));
         else if (pick < 88) begin
            repeat ($urandom_range(1, 4)) send_word(REQ_BYTE, 8'($urandom_range(255)));
         end
         else if (pick < 93) send_word(REQ_UART_ERR, 8'($urandom_range(255)));
         else if (pick < 96) send_word(REQ_UNDEFINED, 8'($urandom_range(255)));
         else send_long_line();
      end
   endtask

   task automatic test_reset_defaults();
      send_text("u\r");
      send_text("L\n");
      send_text("\tpInG \r");
      send_text("\r");
      send_text(" \t\n");
      send_word(REQ_BYTE, "L");
      send_word(REQ_BYTE, CHAR_NUL);
      send_text("Q\r");
      send_word(REQ_BYTE, 8'hFF);
      send_text("z\r");
      send_text("UN");
      send_word(REQ_UART_ERR, 8'h00);
      send_text("P\r");
      send_word(REQ_UNDEFINED, 8'hFF);
      send_word(REQ_TICK, 8'h00);
   endtask

   task automatic test_relock_and_autolock();
      write_reg(REG_HOLD_TIME, 16'd0);
      write_reg(REG_GAP_TIME, 16'd0);
      send_text("LOCK\r");
      send_text("l\r");
      send_text("unlock\r");
      send_word(REQ_TICK, 8'h00);
   endtask

   task automatic test_gap_expiry();
      send_text("P");
      send_word(REQ_TICK, 8'h00);
      send_text("x\r");
      send_text("p");
      send_word(REQ_TICK, 8'h00);
      send_text("\r");
   endtask

   task automatic test_line_overflow();
      repeat (LINE_DEPTH) send_word(REQ_BYTE, "a");
      send_word(REQ_BYTE, "B");
      send_text("ping\r");
   endtask

   task automatic test_random_phase(input int s_pct, input int r_pct,
                                    input logic [15:0] hold, input logic [15:0] gap,
                                    input int count);
      write_reg(REG_HOLD_TIME, hold);
      write_reg(REG_GAP_TIME, gap);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      run_random_traffic(count);
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_replies.size() == 0) begin
            errors++;
            if (errors <= PRINT_CAP) begin
               $display("%0t ns: unexpected reply, expected none, actual %h", $time, rsp_tdata);
            end
         end else begin
            want_reply = pending_replies.pop_front();
            replies_seen++;
            reply_hist[int'(want_reply.code)]++;
            if (rsp_tdata[2:0] !== want_reply.code || rsp_tdata[4:3] !== want_reply.act ||
                rsp_tdata[5] !== want_reply.open) begin
               errors++;
               if (errors <= PRINT_CAP) begin
                  $display({"%0t ns: reply mismatch code exp %0d act %0d open %0d, ",
                            "got %0d %0d %0d"},
                           $time, want_reply.code, want_reply.act, want_reply.open,
                           rsp_tdata[2:0], rsp_tdata[4:3], rsp_tdata[5]);
               end
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_valid = 1'b0;
      csr_index = REG_HOLD_TIME;
      csr_wdata = '0;
      send_idle_pct = 38;
      recv_idle_pct = 51;
      words_sent = 0;
      replies_seen = 0;
      errors = 0;
      foreach (reply_hist[i]) reply_hist[i] = 0;
      hold_ms = HOLD_RESET;
      gap_ms = GAP_RESET;
      now_ms = '0;
      last_byte_ms = '0;
      unlock_ms = '0;
      lock_is_open = 1'b0;
      line_len = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_relock_and_autolock();
      test_gap_expiry();
      test_line_overflow();
      test_random_phase(38, 51, 16'($urandom_range(1, 12)), 16'($urandom_range(1, 6)), 460);
      test_random_phase(51, 38, 16'd0, 16'hFFFF, 460);
      test_random_phase(0, 0, 16'hFFFF, 16'd0, 460);
      settle();

      $display("Sent %0d words (bytes, UART errors, ticks) over three timing settings.",
               words_sent);
      $display({"Checked %0d replies: unlock %0d lock %0d hold %0d ping %0d ",
                "errcmd %0d errlen %0d auto %0d"},
               replies_seen, reply_hist[0], reply_hist[1], reply_hist[2], reply_hist[3],
               reply_hist[4], reply_hist[5], reply_hist[6]);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ serial_lock_command_parser_core.f @@
hdl/slcp_pkg.sv
hdl/slcp_ram.sv
hdl/slcp_alu.sv
hdl/serial_lock_command_parser_core.sv
hdl/slcp_checker.sv
tb/serial_lock_command_parser_core_tb.sv
